// ===== hw/rtl/tpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types and constants for the polled telemetry responder and framer.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // item kinds carried in in_tuser
  localparam logic [1:0] ACT_RX_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_SEND    = 2'd2;

  // configuration register indexes
  localparam logic REG_SERVICE_GAP     = 1'b0;
  localparam logic REG_SILENCE_TIMEOUT = 1'b1;

  // register reset values
  localparam logic [15:0] SERVICE_GAP_RST     = 16'd5;
  localparam logic [15:0] SILENCE_TIMEOUT_RST = 16'd5000;

  // bus bytes
  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] FRAME_HEAD = 8'h10;
  localparam logic [7:0] SENSOR_ID0 = 8'h1B;
  localparam logic [7:0] SENSOR_ID1 = 8'h0D;
  localparam logic [7:0] SENSOR_ID2 = 8'h34;
  localparam logic [7:0] SENSOR_ID3 = 8'h67;
  localparam logic [7:0] SUM_BASE   = 8'hFF;

  // defaults for top-level parameters
  localparam int TIMER_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // one job handed from the front to the back
  typedef struct packed {
    logic        is_frame;   // eight frame bytes, else one status result
    logic [15:0] data_id;
    logic [31:0] payload;
    logic        pending;
    logic        timed_out;
    logic        may_send;
  } tpr_job_t;

endpackage : tpr_pkg
`default_nettype wire

// ===== hw/rtl/tpr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_queue
// Small first-word-fall-through job queue between the front and the back.
// ----------------------------------------------------------------------------
module tpr_queue
  import tpr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tpr_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output tpr_job_t      head_job,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tpr_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // no push into a full queue, no pop from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !pop) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule : tpr_queue
`default_nettype wire

// ===== hw/rtl/tpr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_front
// Accepts bus bytes, ticks and send commands, keeps the poll state, timers
// and configuration, and queues one job per request with its status bits.
// ----------------------------------------------------------------------------
module tpr_front
  import tpr_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [1:0]  req_action,
  input  wire logic [7:0]  req_rx_byte,
  input  wire logic [15:0] req_data_id,
  input  wire logic [31:0] req_payload,
  input  wire logic        q_full,
  output logic             q_push,
  output tpr_job_t         q_job
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic [15:0]           gap_r;
  logic [15:0]           timeout_r;
  logic [7:0]            prev_byte_r, prev_byte_nxt;
  logic                  pending_r, pending_nxt;
  logic                  timed_out_r, timed_out_nxt;
  logic [TIMER_BITS-1:0] poll_ms_r, poll_ms_nxt;
  logic [TIMER_BITS-1:0] send_ms_r, send_ms_nxt;
  logic                  is_sensor;
  logic                  accept;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;
  assign q_push    = accept;

  assign is_sensor = (req_rx_byte == SENSOR_ID0) || (req_rx_byte == SENSOR_ID1) ||
                     (req_rx_byte == SENSOR_ID2) || (req_rx_byte == SENSOR_ID3);

  // state after this request
  always_comb begin
    prev_byte_nxt = prev_byte_r;
    pending_nxt   = pending_r;
    poll_ms_nxt   = poll_ms_r;
    send_ms_nxt   = send_ms_r;
    unique case (req_action)
      ACT_RX_BYTE: begin
        if (prev_byte_r == START_BYTE) begin
          poll_ms_nxt = '0;
          if (is_sensor) begin
            pending_nxt = 1'b1;
          end
        end
        prev_byte_nxt = req_rx_byte;
      end
      ACT_TICK: begin
        poll_ms_nxt = (poll_ms_r == '1) ? poll_ms_r : poll_ms_r + 1'b1;
        send_ms_nxt = (send_ms_r == '1) ? send_ms_r : send_ms_r + 1'b1;
      end
      ACT_SEND: begin
        pending_nxt = 1'b0;
        send_ms_nxt = '0;
      end
      default: begin
      end
    endcase
    timed_out_nxt = timed_out_r || (CMP_W'(poll_ms_nxt) > CMP_W'(timeout_r));
  end

  // job for the back
  always_comb begin
    q_job.is_frame  = (req_action == ACT_SEND);
    q_job.data_id   = req_data_id;
    q_job.payload   = req_payload;
    q_job.pending   = pending_nxt;
    q_job.timed_out = timed_out_nxt;
    q_job.may_send  = pending_nxt && !timed_out_nxt &&
                      (CMP_W'(send_ms_nxt) >= CMP_W'(gap_r));
  end

  // poll state and timers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= '0;
      pending_r   <= 1'b0;
      timed_out_r <= 1'b0;
      poll_ms_r   <= '0;
      send_ms_r   <= '0;
    end else if (accept) begin
      prev_byte_r <= prev_byte_nxt;
      pending_r   <= pending_nxt;
      timed_out_r <= timed_out_nxt;
      poll_ms_r   <= poll_ms_nxt;
      send_ms_r   <= send_ms_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r     <= SERVICE_GAP_RST;
      timeout_r <= SILENCE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SERVICE_GAP:     gap_r     <= cfg_wdata;
        REG_SILENCE_TIMEOUT: timeout_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // timed-out flag is sticky until reset
  a_timeout_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    timed_out_r |=> timed_out_r) else $error("timed-out flag dropped");
  // a send always leaves the request cleared
  a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req_action == ACT_SEND |=> !pending_r && send_ms_r == '0)
    else $error("send did not clear pending state");
  // a sensor poll right after the start byte marks a request
  a_poll_marks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req_action == ACT_RX_BYTE && prev_byte_r == START_BYTE && is_sensor
    |=> pending_r) else $error("poll not marked pending");

endmodule : tpr_front
`default_nettype wire

// ===== hw/rtl/tpr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpr_back
// Drains queued jobs into the result register: one status result, or eight
// frame bytes one a cycle while not stalled, checksum built on the way.
// ----------------------------------------------------------------------------
module tpr_back
  import tpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_not_empty,
  input  wire tpr_job_t q_head,
  output logic          q_pop,
  output logic          res_valid,
  input  wire logic     res_ready,
  output logic [7:0]    res_tx_byte,
  output logic          res_tx_valid,
  output logic          res_last,
  output logic          res_pending,
  output logic          res_timed_out,
  output logic          res_may_send
);

  logic       out_valid_r;
  logic [7:0] tx_byte_r;
  logic       tx_valid_r;
  logic       last_r;
  logic       pending_r;
  logic       timed_out_r;
  logic       may_send_r;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] byte_sel;
  logic       load;
  logic       job_done;

  // end-around-carry byte add
  function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, s} + {1'b0, b};
    t = {1'b0, t[7:0]} + {8'd0, t[8]};
    t = {1'b0, t[7:0]} + {8'd0, t[8]};
    return t[7:0];
  endfunction

  assign load     = q_not_empty && (!out_valid_r || res_ready);
  assign job_done = !q_head.is_frame || (idx_r == 3'd7);
  assign q_pop    = load && job_done;

  // frame byte for this position
  always_comb begin
    unique case (idx_r)
      3'd0:    byte_sel = FRAME_HEAD;
      3'd1:    byte_sel = q_head.data_id[7:0];
      3'd2:    byte_sel = q_head.data_id[15:8];
      3'd3:    byte_sel = q_head.payload[7:0];
      3'd4:    byte_sel = q_head.payload[15:8];
      3'd5:    byte_sel = q_head.payload[23:16];
      3'd6:    byte_sel = q_head.payload[31:24];
      default: byte_sel = SUM_BASE - sum_r;
    endcase
  end

  // byte position and running sum
  always_comb begin
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    if (load && q_head.is_frame) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == 3'd0) begin
        sum_nxt = sum_add(8'd0, byte_sel);
      end else if (idx_r != 3'd7) begin
        sum_nxt = sum_add(sum_r, byte_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      sum_r <= sum_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r   <= q_head.is_frame ? byte_sel : 8'd0;
      tx_valid_r  <= q_head.is_frame;
      last_r      <= job_done;
      pending_r   <= q_head.pending;
      timed_out_r <= q_head.timed_out;
      may_send_r  <= q_head.may_send;
    end
  end

  assign res_valid     = out_valid_r;
  assign res_tx_byte   = tx_byte_r;
  assign res_tx_valid  = tx_valid_r;
  assign res_last      = last_r;
  assign res_pending   = pending_r;
  assign res_timed_out = timed_out_r;
  assign res_may_send  = may_send_r;

  // a status result is always the only result of its request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !tx_valid_r |-> last_r) else $error("status result not last");
  // mid-frame the head of the queue must be a frame job
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 3'd0 |-> q_not_empty && q_head.is_frame)
    else $error("frame position without frame job");
  // the checksum byte closes the frame and rewinds the position
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && tx_valid_r && last_r |-> idx_r == 3'd0)
    else $error("frame ended out of step");

endmodule : tpr_back
`default_nettype wire

// ===== hw/rtl/telemetry_poll_responder_framer_top.sv =====
`default_nettype none
// Flow: an accepted request passes the job queue, then the result register.
// Throughput: one request a cycle unless the queue is full; a send request
//   gives eight frame bytes (one frame byte a cycle from the back's byte
//   sequencer unless stalled), others one status result; the queue absorbs bursts.
// Reset: synchronous, active low; clears timers, flags, queue and result valid
//   flag, and loads the service gap (5) and silence timeout (5000).
// ----------------------------------------------------------------------------
// telemetry_poll_responder_framer_top
// Sensor side of a polled serial telemetry link: poll tracking, timers and
// eight-byte frame builder.
// ----------------------------------------------------------------------------
module telemetry_poll_responder_framer_top
  import tpr_pkg::*;
#(
  parameter int TIMER_BITS  = TIMER_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // rx_byte[7:0], data_id[23:8], payload[55:24]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // tx_byte[7:0], request_pending[8],
                                       // timed_out[9], may_send[10], zero[15:11]
  output logic             out_tuser,  // tx_valid
  output logic             out_tlast
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  tpr_job_t q_job;
  tpr_job_t q_head;
  logic [7:0] tx_byte;
  logic     pending;
  logic     timed_out;
  logic     may_send;

  // front: classify and track poll state
  tpr_front #(
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_action  (in_tuser),
    .req_rx_byte (in_tdata[7:0]),
    .req_data_id (in_tdata[23:8]),
    .req_payload (in_tdata[55:24]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  // job queue
  tpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .head_job  (q_head),
    .not_empty (q_not_empty)
  );

  // back: result sequencing
  tpr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_tx_byte   (tx_byte),
    .res_tx_valid  (out_tuser),
    .res_last      (out_tlast),
    .res_pending   (pending),
    .res_timed_out (timed_out),
    .res_may_send  (may_send)
  );

  assign out_tdata = {5'd0, may_send, timed_out, pending, tx_byte};

endmodule : telemetry_poll_responder_framer_top
`default_nettype wire

// ===== verif/telemetry_poll_responder_framer_top_test.sv =====
// ----------------------------------------------------------------------------
// telemetry_poll_responder_framer_top_test
// Self-checking bench for the polled telemetry responder. It drives received
// bus bytes, millisecond ticks and send commands, keeps its own copy of the
// poll tracking, timers and frame checksum, and checks every status and frame
// byte in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module telemetry_poll_responder_framer_top_test;
  import tpr_pkg::*;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam int         TIMER_W       = TIMER_BITS_DEF;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         REPORT_LIMIT  = 20;
  localparam int         PHASE_ITEMS   = 35;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic       pending;
    logic       timed_out;
    logic       may_send;
  } tx_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = REG_SERVICE_GAP;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;  // rx_byte[7:0], data_id[23:8], payload[55:24]
  logic [1:0]  in_tuser   = ACT_TICK;  // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // tx_byte[7:0], request_pending[8],
                                 // timed_out[9], may_send[10], zero[15:11]
  logic        out_tuser;        // tx_valid
  logic        out_tlast;

  telemetry_poll_responder_framer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predicted responder state and register copies
  logic [7:0]         last_rx        = '0;
  logic               poll_pending   = 1'b0;
  logic               link_timed_out = 1'b0;
  logic [TIMER_W-1:0] ms_poll        = '0;
  logic [TIMER_W-1:0] ms_send        = '0;
  logic [15:0]        gap_ms         = SERVICE_GAP_RST;
  logic [15:0]        silence_ms     = SILENCE_TIMEOUT_RST;
  tx_beat_t           awaited_beats[$];

  // run control and bookkeeping
  bit sender_gaps    = 1'b1;
  bit sink_stalls    = 1'b1;
  int mismatches     = 0;
  int beats_checked  = 0;
  int requests_seen  = 0;
  int frames_sent    = 0;
  int sensor_polls   = 0;
  int stall_cycles   = 0;

  // clock
  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] any_sensor_id();
    case ($urandom_range(0, 3))
      0:       return SENSOR_ID0;
      1:       return SENSOR_ID1;
      2:       return SENSOR_ID2;
      default: return SENSOR_ID3;
    endcase
  endfunction

  // queue one expected beat, status taken from the state after the request
  function automatic void queue_beat(input logic [7:0] b, input logic v, input logic l);
    tx_beat_t e;
    e.tx_byte   = b;
    e.tx_valid  = v;
    e.last      = l;
    e.pending   = poll_pending;
    e.timed_out = link_timed_out;
    e.may_send  = poll_pending && !link_timed_out && (ms_send >= gap_ms);
    awaited_beats.push_back(e);
  endfunction

  // poll tracking, timers and frame builder for one accepted request
  function automatic void predict_request(input logic [1:0] act, input logic [7:0] rx,
                                          input logic [15:0] id, input logic [31:0] val);
    logic [7:0] fb [8];
    logic [8:0] acc;
    logic [7:0] sum;
    fb[0] = FRAME_HEAD;
    fb[1] = id[7:0];
    fb[2] = id[15:8];
    fb[3] = val[7:0];
    fb[4] = val[15:8];
    fb[5] = val[23:16];
    fb[6] = val[31:24];
    fb[7] = '0;
    if (act == ACT_SEND) begin
      // end-around-carry sum over head, id and payload
      sum = '0;
      for (int k = 0; k < 7; k++) begin
        acc = sum + fb[k];
        sum = acc[7:0] + acc[8];
      end
      fb[7] = SUM_BASE - sum;
      poll_pending = 1'b0;
      ms_send = '0;
      frames_sent++;
    end else if (act == ACT_RX_BYTE) begin
      // byte after a start byte restarts the silence timer
      if (last_rx == START_BYTE) begin
        ms_poll = '0;
        if (rx == SENSOR_ID0 || rx == SENSOR_ID1 || rx == SENSOR_ID2 || rx == SENSOR_ID3)
        begin
          poll_pending = 1'b1;
          sensor_polls++;
        end
      end
      last_rx = rx;
    end else if (act == ACT_TICK) begin
      // saturating millisecond timers
      if (ms_poll != '1) ms_poll = ms_poll + 1'b1;
      if (ms_send != '1) ms_send = ms_send + 1'b1;
    end
    if (ms_poll > silence_ms) link_timed_out = 1'b1;
    if (act == ACT_SEND) begin
      for (int k = 0; k < 8; k++) queue_beat(fb[k], 1'b1, k == 7);
    end else begin
      queue_beat(8'h00, 1'b0, 1'b1);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // result checking, register shadowing and request prediction at each edge
  always @(posedge clk) begin : scoreboard
    tx_beat_t want;
    tx_beat_t got;
    bit       moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        beats_checked++;
        got.tx_byte   = out_tdata[7:0];
        got.tx_valid  = out_tuser;
        got.last      = out_tlast;
        got.pending   = out_tdata[8];
        got.timed_out = out_tdata[9];
        got.may_send  = out_tdata[10];
        if (awaited_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result with nothing outstanding, expected none actual %h",
                     $time, got);
        end else begin
          want = awaited_beats.pop_front();
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("tx_valid", want.tx_valid, got.tx_valid);
          check_field("last", want.last, got.last);
          check_field("request_pending", want.pending, got.pending);
          check_field("timed_out", want.timed_out, got.timed_out);
          check_field("may_send", want.may_send, got.may_send);
        end
      end
      if (cfg_we) begin
        moved = 1'b1;
        if (cfg_index == REG_SERVICE_GAP) gap_ms = cfg_wdata;
        else silence_ms = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        requests_seen++;
        predict_request(in_tuser, in_tdata[7:0], in_tdata[23:8], in_tdata[55:24]);
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // no progress on any port for too long
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("telemetry_poll_responder_framer_top_test: FAIL");
    $finish;
  end

  // result side back-pressure
  initial begin : result_sink
    int run;
    int hold;
    forever begin
      out_tready <= 1'b1;
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      hold = sink_stalls ? pick_gap() : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // send one request and wait for its handshake
  task automatic push_request(input logic [1:0] act, input logic [7:0] rx,
                              input logic [15:0] id, input logic [31:0] val);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {val, id, rx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_byte(input logic [7:0] rx);
    push_request(ACT_RX_BYTE, rx, 16'($urandom), $urandom);
  endtask

  task automatic push_tick();
    push_request(ACT_TICK, 8'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic push_frame(input logic [15:0] id, input logic [31:0] val);
    push_request(ACT_SEND, 8'($urandom), id, val);
  endtask

  task automatic poll(input logic [7:0] id);
    push_byte(START_BYTE);
    push_byte(id);
  endtask

  // hold off until every outstanding result has come and the pipe is empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] gap, input logic [15:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SERVICE_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= REG_SILENCE_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // all sensor ids, start byte corner cases, extreme frames, unused action
  task automatic test_directed_frames();
    poll(SENSOR_ID0);
    // may_send comes up once the default service gap has passed
    repeat (5) push_tick();
    push_frame(16'hFFFF, 32'hFFFF_FFFF);
    poll(SENSOR_ID1);
    poll(SENSOR_ID2);
    poll(SENSOR_ID3);
    // repeated start byte, then an id right after the second one
    push_byte(START_BYTE);
    poll(SENSOR_ID0);
    push_frame(16'h0000, 32'h0000_0000);
    // id without a start byte in front does not count as a poll
    push_byte(SENSOR_ID1);
    poll(8'h00);
    push_byte(8'hFF);
    push_request(ACT_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    // start and escape lookalikes go out unstuffed
    push_frame(16'h7D7E, 32'h7E7D_7E7D);
    push_frame(16'h5A5A, 32'h8000_0001);
  endtask

  // zero service gap: may_send as soon as a poll arrives
  task automatic test_service_gap_zero();
    wait_drained();
    set_config(16'h0000, 16'hFFFF);
    poll(SENSOR_ID3);
    push_frame(16'($urandom), $urandom);
    poll(SENSOR_ID2);
    push_tick();
    push_frame(16'($urandom), $urandom);
  endtask

  // mostly poll / wait / answer sequences, with loose bytes and ticks between
  task automatic test_random_traffic();
    int count;
    int pick;
    int ticks;
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0:       set_config(16'($urandom_range(0, 8)), 16'hFFFF);
        1:       set_config(16'($urandom_range(1, 4)), SILENCE_TIMEOUT_RST);
        2:       set_config(16'hFFFF, 16'($urandom_range(300, 2000)));
        default: set_config(16'($urandom_range(0, 4)), 16'($urandom_range(300, 65535)));
      endcase
      // last phase runs without idling on either side
      sender_gaps = (phase != 3);
      sink_stalls = (phase != 3);
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        n = 0;
        if (pick < 50) begin
          push_byte(START_BYTE);
          push_byte(($urandom_range(0, 9) < 7) ? any_sensor_id() : 8'($urandom));
          ticks = $urandom_range(0, 8);
          repeat (ticks) push_tick();
          n = 2 + ticks;
          if ($urandom_range(0, 9) < 7) begin
            push_frame(16'($urandom), $urandom);
            n++;
          end
        end else if (pick < 70) begin
          ticks = $urandom_range(1, 6);
          repeat (ticks) push_tick();
          n = ticks;
        end else if (pick < 85) begin
          push_byte(($urandom_range(0, 3) == 0) ? START_BYTE : 8'($urandom));
          n = 1;
        end else if (pick < 95) begin
          push_frame(16'($urandom), $urandom);
          n = 1;
        end else begin
          push_request(ACT_UNUSED, 8'($urandom), 16'($urandom), $urandom);
        end
        count += n;
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // timeout boundary, sticky flag, then zero timeout and zero gap
  task automatic test_silence_timeout();
    poll(SENSOR_ID0);
    wait_drained();
    set_config(16'd2, 16'd4);
    repeat (4) push_tick();
    push_tick();
    poll(SENSOR_ID3);
    push_tick();
    push_frame(16'($urandom), $urandom);
    wait_drained();
    set_config(16'h0000, 16'h0000);
    poll(SENSOR_ID1);
    push_tick();
    push_byte(8'($urandom));
    push_frame(16'($urandom), $urandom);
  endtask

  initial begin : run_tests
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_service_gap_zero();
    test_random_traffic();
    test_silence_timeout();
    wait_drained();
    $display("covered %0d requests: %0d frames, %0d sensor polls, gap and timeout 0 to 65535",
             requests_seen, frames_sent, sensor_polls);
    $display("%0d result beats checked, incl. the timeout boundary and sticky time-out",
             beats_checked);
    if (mismatches == 0) begin
      $display("telemetry_poll_responder_framer_top_test: PASS");
    end else begin
      $display("telemetry_poll_responder_framer_top_test: FAIL");
    end
    $finish;
  end

endmodule
